[hw/rtl/light_level_classifier_core_defines.svh]
// assertion macros shared by the checker of the light level classifier
// no dependencies; included by files that hold concurrent assertions
`ifndef LIGHT_LEVEL_CLASSIFIER_CORE_DEFINES_SVH
`define LIGHT_LEVEL_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define LLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/llc_pkg.sv]
// shared widths, codes and reset values of the light level classifier
// no dependencies; imported by every module of the block
package llc_pkg;

  localparam int ADC_W      = 10;
  localparam int ADC_MAX    = 1023;
  localparam int LUX_W      = 17;
  localparam int LUX_FRAC   = 4;
  localparam int LUX_INT_W  = LUX_W - LUX_FRAC;
  localparam int LUX_TOP    = (1 << LUX_W) - 1;
  localparam int GAIN_W     = 18;
  localparam int BFL_W      = 13;
  localparam int LVL_W      = 8;
  localparam int CLASS_W    = 2;
  localparam int SCALE_SH   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int WINDOW_DEF     = 10;
  localparam int OVERSAMPLE_DEF = 5;

  localparam logic [LVL_W-1:0] LVL_MAX = 8'd255;
  localparam logic [LVL_W-1:0] LVL_OFF = 8'd0;

  localparam logic [CLASS_W-1:0] CLASS_DARK   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_NORMAL = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_BRIGHT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LUX_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_FULL = 3'd5;

  localparam logic [LUX_W-1:0]  CAL_OFFSET_RST  = 17'd26852;
  localparam logic [GAIN_W-1:0] CAL_GAIN_RST    = 18'd32031;
  localparam logic [LUX_W-1:0]  LUX_MAX_RST     = 17'd80000;
  localparam logic [LUX_W-1:0]  DARK_LIMIT_RST  = 17'd4800;
  localparam logic [LUX_W-1:0]  NORMAL_MAX_RST  = 17'd12800;
  localparam logic [BFL_W-1:0]  BRIGHT_FULL_RST = 13'd2000;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[hw/rtl/llc_calib.sv]
// two-stage calibration: group sum times gain, then offset subtract and clamp
// depends on llc_pkg
module llc_calib import llc_pkg::*; #(
  parameter int SUM_W = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [GAIN_W-1:0] gain_i,
  input  logic [LUX_W-1:0]  offset_i,
  input  logic [LUX_W-1:0]  lux_max_i,
  output logic              valid_o,
  output logic [LUX_W-1:0]  raw_o,
  output logic              clamped_o
);

  localparam int PROD_W = GAIN_W + SUM_W;
  localparam int POS_W  = LUX_W + SCALE_SH;
  localparam int CMP_W  = max_int(PROD_W, POS_W);
  localparam int V_W    = CMP_W - SCALE_SH;

  logic [PROD_W-1:0] prod_q;
  logic              s1_q, s2_q;
  logic [LUX_W-1:0]  raw_q, raw_d;
  logic              clamped_q, clamped_d;
  logic [CMP_W-1:0]  prod_ext, pos_ext, diff;
  logic [V_W-1:0]    v_val;

  always_comb begin
    prod_ext  = CMP_W'(prod_q);
    pos_ext   = CMP_W'({offset_i, {SCALE_SH{1'b0}}});
    diff      = pos_ext - prod_ext;
    v_val     = diff[CMP_W-1:SCALE_SH];
    clamped_d = prod_ext > pos_ext;
    if (clamped_d) begin
      raw_d = '0;
    end else if (v_val > V_W'(lux_max_i)) begin
      raw_d = lux_max_i;
    end else begin
      raw_d = v_val[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= start_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PROD_W'(gain_i) * PROD_W'(sum_i);
    end
    if (s1_q) begin
      raw_q     <= raw_d;
      clamped_q <= clamped_d;
    end
  end

  assign valid_o   = s2_q;
  assign raw_o     = raw_q;
  assign clamped_o = clamped_q;

endmodule

[hw/rtl/llc_window_ram.sv]
// moving-average window store: one write port, one registered read port
// depends on llc_pkg
module llc_window_ram import llc_pkg::*; #(
  parameter int DEPTH = WINDOW_DEF,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [LUX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [LUX_W-1:0] rdata_o
);

  logic [LUX_W-1:0] mem_q [DEPTH];
  logic [LUX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/llc_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on llc_pkg
module llc_div import llc_pkg::*; #(
  parameter int DW  = 21,
  parameter int DVW = 13
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           done_o,
  output logic [DW-1:0]  quo_o
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_q;
  logic [DVW-1:0]   rem_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DVW:0]     trial, trial_sub;
  logic             ge;

  always_comb begin
    trial     = {rem_q, quo_q[DW-1]};
    trial_sub = trial - {1'b0, dvs_q};
    ge        = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? trial_sub[DVW-1:0] : trial[DVW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hw/rtl/light_level_classifier_core.sv]
// top level of the light level classifier: sequencer, window total, outputs
// depends on llc_pkg, llc_calib, llc_window_ram, llc_div
//
// channel  direction  handshake                  payload
// in       sink       in_valid_i / in_stall_o    adc_sample_i
// out      source     out_valid_o / out_stall_i  raw_lux_q4_o .. buzzer_on_o
// cfg      sink       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// an item that does not close a group only adds to the group sum; a closing item
// runs calibration, the average division (DIV_W = 21 by default), the class step
// and, for a bright result with a nonempty span, the gradient division in turn
// reset loads the register defaults and empties the group and the window
// the finished result waits in the output register; a stalled output holds
// the sequencer in its last step until the register is free
module light_level_classifier_core import llc_pkg::*; #(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int OVERSAMPLE = OVERSAMPLE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADC_W-1:0]      adc_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LUX_W-1:0]      raw_lux_q4_o,
  output logic                  clamped_low_o,
  output logic [LUX_W-1:0]      avg_lux_q4_o,
  output logic [CLASS_W-1:0]    light_class_o,
  output logic [LVL_W-1:0]      red_level_o,
  output logic [LVL_W-1:0]      green_level_o,
  output logic [LVL_W-1:0]      blue_level_o,
  output logic                  buzzer_on_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SUM_W = $clog2(OVERSAMPLE * ADC_MAX + 1);
  localparam int GCW   = $clog2(OVERSAMPLE + 1);
  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TOT_W = $clog2(WINDOW * LUX_TOP + 1);
  localparam int NUM_W = LUX_INT_W + LVL_W;
  localparam int DIV_W = max_int(TOT_W, NUM_W);
  localparam int DVS_W = max_int(BFL_W, $clog2(WINDOW + 1));

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CALIB = 6'b000010,
    S_DIVA  = 6'b000100,
    S_CLASS = 6'b001000,
    S_DIVG  = 6'b010000,
    S_PUSH  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [LUX_W-1:0]  offset_q, lux_max_q, dark_q, normal_q;
  logic [GAIN_W-1:0] gain_q;
  logic [BFL_W-1:0]  bff_q;

  // group and window state
  logic [SUM_W-1:0] group_sum_q, group_sum_d, sum_next;
  logic [GCW-1:0]   group_cnt_q, group_cnt_d;
  logic [AW-1:0]    slot_q, slot_d;
  logic             full_q, full_d;
  logic [TOT_W-1:0] total_q, total_d, old_val;
  logic             slot_last, last_item, in_acc;
  logic [DVS_W-1:0] count_val;

  // result registers
  logic [LUX_W-1:0]   avg_q, avg_d;
  logic [CLASS_W-1:0] cls_q, cls_d;
  logic [LVL_W-1:0]   red_q, red_d, grn_q, grn_d;
  logic               buz_q, buz_d;

  // output register
  logic               out_valid_q, out_valid_d, out_load;
  logic [LUX_W-1:0]   o_raw_q, o_avg_q;
  logic               o_flag_q, o_buz_q;
  logic [CLASS_W-1:0] o_cls_q;
  logic [LVL_W-1:0]   o_red_q, o_grn_q;

  // calibration, store and divider hookup
  logic             calib_start, calib_valid, calib_flag;
  logic [LUX_W-1:0] calib_raw, ram_rdata;
  logic             ram_we, ram_re;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0] div_divisor;

  // gradient terms
  logic [LUX_INT_W-1:0] x_int, lo_int, dx;
  logic [BFL_W-1:0]     span;
  logic [NUM_W-1:0]     num;
  logic [LVL_W-1:0]     inten;
  logic                 is_dark, is_normal, flat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_item  = (group_cnt_q == GCW'(OVERSAMPLE - 1));
  assign sum_next   = group_sum_q + SUM_W'(adc_sample_i);

  assign slot_last = (slot_q == AW'(WINDOW - 1));
  assign old_val   = full_q ? TOT_W'(ram_rdata) : '0;
  assign count_val = (full_q || slot_last) ? DVS_W'(WINDOW) : DVS_W'(slot_q) + DVS_W'(1);

  assign is_dark   = avg_q < dark_q;
  assign is_normal = avg_q <= normal_q;
  assign x_int     = avg_q[LUX_W-1:LUX_FRAC];
  assign lo_int    = normal_q[LUX_W-1:LUX_FRAC];
  assign flat      = bff_q <= lo_int;
  assign dx        = x_int - lo_int;
  assign span      = bff_q - lo_int;
  assign num       = NUM_W'(dx) * NUM_W'(LVL_MAX);
  assign inten     = (|div_quo[DIV_W-1:LVL_W]) ? LVL_MAX : div_quo[LVL_W-1:0];

  assign out_load  = (state_q == S_PUSH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    group_sum_d  = group_sum_q;
    group_cnt_d  = group_cnt_q;
    slot_d       = slot_q;
    full_d       = full_q;
    total_d      = total_q;
    avg_d        = avg_q;
    cls_d        = cls_q;
    red_d        = red_q;
    grn_d        = grn_q;
    buz_d        = buz_q;
    calib_start  = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(total_d);
    div_divisor  = count_val;
    out_valid_d  = out_valid_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (last_item) begin
            group_sum_d = '0;
            group_cnt_d = '0;
            calib_start = 1'b1;
            ram_re      = 1'b1;
            state_d     = S_CALIB;
          end else begin
            group_sum_d = sum_next;
            group_cnt_d = group_cnt_q + GCW'(1);
          end
        end
      end
      S_CALIB: begin
        if (calib_valid) begin
          total_d      = total_q - old_val + TOT_W'(calib_raw);
          ram_we       = 1'b1;
          slot_d       = slot_last ? '0 : slot_q + AW'(1);
          full_d       = full_q || slot_last;
          div_start    = 1'b1;
          div_dividend = DIV_W'(total_d);
          div_divisor  = count_val;
          state_d      = S_DIVA;
        end
      end
      S_DIVA: begin
        if (div_done) begin
          avg_d   = div_quo[LUX_W-1:0];
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        if (is_dark) begin
          cls_d   = CLASS_DARK;
          red_d   = LVL_OFF;
          grn_d   = LVL_OFF;
          buz_d   = 1'b1;
          state_d = S_PUSH;
        end else if (is_normal) begin
          cls_d   = CLASS_NORMAL;
          red_d   = LVL_MAX;
          grn_d   = LVL_MAX;
          buz_d   = 1'b0;
          state_d = S_PUSH;
        end else begin
          cls_d = CLASS_BRIGHT;
          red_d = LVL_MAX;
          buz_d = 1'b0;
          if (flat) begin
            grn_d   = LVL_OFF;
            state_d = S_PUSH;
          end else begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(num);
            div_divisor  = DVS_W'(span);
            state_d      = S_DIVG;
          end
        end
      end
      S_DIVG: begin
        if (div_done) begin
          grn_d   = LVL_MAX - inten;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      group_sum_q <= '0;
      group_cnt_q <= '0;
      slot_q      <= '0;
      full_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      group_sum_q <= group_sum_d;
      group_cnt_q <= group_cnt_d;
      slot_q      <= slot_d;
      full_q      <= full_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= CAL_OFFSET_RST;
      gain_q    <= CAL_GAIN_RST;
      lux_max_q <= LUX_MAX_RST;
      dark_q    <= DARK_LIMIT_RST;
      normal_q  <= NORMAL_MAX_RST;
      bff_q     <= BRIGHT_FULL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAL_OFFSET:  offset_q  <= cfg_data_i[LUX_W-1:0];
        CFG_CAL_GAIN:    gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_LUX_MAX:     lux_max_q <= cfg_data_i[LUX_W-1:0];
        CFG_DARK_LIMIT:  dark_q    <= cfg_data_i[LUX_W-1:0];
        CFG_NORMAL_MAX:  normal_q  <= cfg_data_i[LUX_W-1:0];
        CFG_BRIGHT_FULL: bff_q     <= cfg_data_i[BFL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
    cls_q <= cls_d;
    red_q <= red_d;
    grn_q <= grn_d;
    buz_q <= buz_d;
    if (out_load) begin
      o_raw_q  <= calib_raw;
      o_flag_q <= calib_flag;
      o_avg_q  <= avg_q;
      o_cls_q  <= cls_q;
      o_red_q  <= red_q;
      o_grn_q  <= grn_q;
      o_buz_q  <= buz_q;
    end
  end

  llc_calib #(
    .SUM_W(SUM_W)
  ) u_calib (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (calib_start),
    .sum_i     (sum_next),
    .gain_i    (gain_q),
    .offset_i  (offset_q),
    .lux_max_i (lux_max_q),
    .valid_o   (calib_valid),
    .raw_o     (calib_raw),
    .clamped_o (calib_flag)
  );

  llc_window_ram #(
    .DEPTH(WINDOW),
    .AW   (AW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (calib_raw),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  llc_div #(
    .DW (DIV_W),
    .DVW(DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign out_valid_o   = out_valid_q;
  assign raw_lux_q4_o  = o_raw_q;
  assign clamped_low_o = o_flag_q;
  assign avg_lux_q4_o  = o_avg_q;
  assign light_class_o = o_cls_q;
  assign red_level_o   = o_red_q;
  assign green_level_o = o_grn_q;
  assign blue_level_o  = o_grn_q;
  assign buzzer_on_o   = o_buz_q;

endmodule

[hw/rtl/llc_checker.sv]
// port-level checks of the light level classifier, bound to the top level
// depends on llc_pkg and light_level_classifier_core_defines.svh
`include "light_level_classifier_core_defines.svh"

module llc_checker import llc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [LUX_W-1:0]   raw_lux_q4_o,
  input logic               clamped_low_o,
  input logic [LUX_W-1:0]   avg_lux_q4_o,
  input logic [CLASS_W-1:0] light_class_o,
  input logic [LVL_W-1:0]   red_level_o,
  input logic [LVL_W-1:0]   green_level_o,
  input logic [LVL_W-1:0]   blue_level_o,
  input logic               buzzer_on_o
);

  // stalled transaction stays valid and keeps its raw lux, average and class
  `LLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(raw_lux_q4_o) && $stable(avg_lux_q4_o) && $stable(light_class_o), "output changed while stalled")

  `LLC_ASSERT_IMP(a_dark_levels, clk_i, rst_ni, out_valid_o && (light_class_o == CLASS_DARK), buzzer_on_o && (red_level_o == LVL_OFF) && (green_level_o == LVL_OFF) && (blue_level_o == LVL_OFF), "dark result with led drive or no buzzer")

  `LLC_ASSERT_IMP(a_lit_levels, clk_i, rst_ni, out_valid_o && (light_class_o != CLASS_DARK), !buzzer_on_o && (red_level_o == LVL_MAX) && (green_level_o == blue_level_o), "lit result with wrong red or buzzer")

  `LLC_ASSERT_IMP(a_clamp_zero, clk_i, rst_ni, out_valid_o && clamped_low_o, raw_lux_q4_o == '0, "low clamp flagged with nonzero lux")

endmodule

bind light_level_classifier_core llc_checker u_llc_checker (.*);

[test/testbench.sv]
// self-checking testbench for light_level_classifier_core: random and directed adc samples
// under several register settings and handshake idling patterns, checked by an internal model
// depends on llc_pkg and the light_level_classifier_core rtl
module testbench;
  import llc_pkg::*;

  localparam int WINDOW          = WINDOW_DEF;
  localparam int OVERSAMPLE      = OVERSAMPLE_DEF;
  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int DRAIN_CYCLES    = 100;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PRINT_LIMIT     = 30;

  typedef struct packed {
    logic [LUX_W-1:0]   raw_lux;
    logic               clamped;
    logic [LUX_W-1:0]   avg_lux;
    logic [CLASS_W-1:0] light_class;
    logic [LVL_W-1:0]   red;
    logic [LVL_W-1:0]   green;
    logic [LVL_W-1:0]   blue;
    logic               buzzer;
  } lux_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADC_W-1:0]      adc_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LUX_W-1:0]      raw_lux_q4;
  logic                  clamped_low;
  logic [LUX_W-1:0]      avg_lux_q4;
  logic [CLASS_W-1:0]    light_class;
  logic [LVL_W-1:0]      red_level;
  logic [LVL_W-1:0]      green_level;
  logic [LVL_W-1:0]      blue_level;
  logic                  buzzer_on;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model copy of the registers and the averaging state
  logic [LUX_W-1:0]  cal_offset   = CAL_OFFSET_RST;
  logic [GAIN_W-1:0] cal_gain     = CAL_GAIN_RST;
  logic [LUX_W-1:0]  lux_max      = LUX_MAX_RST;
  logic [LUX_W-1:0]  dark_limit   = DARK_LIMIT_RST;
  logic [LUX_W-1:0]  normal_limit = NORMAL_MAX_RST;
  logic [BFL_W-1:0]  bright_full  = BRIGHT_FULL_RST;
  int unsigned       group_sum = 0;
  int unsigned       group_count = 0;
  int unsigned       window_lux [WINDOW];
  int unsigned       write_slot = 0;
  bit                window_full = 1'b0;
  int unsigned       window_total = 0;

  logic [ADC_W-1:0] pending_samples [$];
  lux_report_t      expected_reports [$];
  lux_report_t      fresh_report;
  lux_report_t      next_report;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int low_clamps = 0;
  int settings_used = 1;
  int class_tally [3] = '{0, 0, 0};
  int cycle_count = 0;

  light_level_classifier_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .adc_sample_i  (adc_sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .raw_lux_q4_o  (raw_lux_q4),
    .clamped_low_o (clamped_low),
    .avg_lux_q4_o  (avg_lux_q4),
    .light_class_o (light_class),
    .red_level_o   (red_level),
    .green_level_o (green_level),
    .blue_level_o  (blue_level),
    .buzzer_on_o   (buzzer_on),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // adds one sample to the group; a closed group yields the expected lux report
  function automatic bit accumulate_sample(input logic [ADC_W-1:0] sample,
                                           output lux_report_t rep);
    longint unsigned offset_scaled;
    longint unsigned loss;
    int unsigned raw;
    int unsigned avg;
    int unsigned fill;
    int unsigned x;
    int unsigned lo;
    int unsigned level;
    rep = '0;
    group_sum += sample;
    group_count++;
    if (group_count < OVERSAMPLE) return 1'b0;
    offset_scaled = cal_offset;
    offset_scaled = offset_scaled << SCALE_SH;
    loss = cal_gain;
    loss = loss * group_sum;
    group_sum = 0;
    group_count = 0;
    if (loss > offset_scaled) begin
      raw = 0;
      rep.clamped = 1'b1;
    end else begin
      offset_scaled = (offset_scaled - loss) >> SCALE_SH;
      raw = (offset_scaled > lux_max) ? lux_max : offset_scaled;
      rep.clamped = 1'b0;
    end
    if (window_full) window_total -= window_lux[write_slot];
    window_lux[write_slot] = raw;
    window_total += raw;
    write_slot++;
    if (write_slot >= WINDOW) begin
      write_slot = 0;
      window_full = 1'b1;
    end
    fill = window_full ? WINDOW : write_slot;
    avg = window_total / fill;
    rep.raw_lux = raw;
    rep.avg_lux = avg;
    if (avg < dark_limit) begin
      rep.light_class = CLASS_DARK;
      rep.red = LVL_OFF;
      rep.green = LVL_OFF;
      rep.blue = LVL_OFF;
      rep.buzzer = 1'b1;
    end else if (avg <= normal_limit) begin
      rep.light_class = CLASS_NORMAL;
      rep.red = LVL_MAX;
      rep.green = LVL_MAX;
      rep.blue = LVL_MAX;
      rep.buzzer = 1'b0;
    end else begin
      x = avg >> LUX_FRAC;
      lo = normal_limit >> LUX_FRAC;
      // gradient collapses to full intensity when its span is empty
      if (bright_full <= lo) level = 255;
      else level = ((x - lo) * 255) / (bright_full - lo);
      if (level > 255) level = 255;
      rep.light_class = CLASS_BRIGHT;
      rep.red = LVL_MAX;
      rep.green = LVL_MAX - level[LVL_W-1:0];
      rep.blue = LVL_MAX - level[LVL_W-1:0];
      rep.buzzer = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
  endtask

  // driver: offers queued samples, holds them while stalled
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      adc_sample <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        samples_sent++;
        if (accumulate_sample(adc_sample, fresh_report)) expected_reports.push_back(fresh_report);
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          adc_sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest expectation
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          next_report = expected_reports.pop_front();
          check_field("raw_lux_q4", raw_lux_q4, next_report.raw_lux);
          check_field("clamped_low", clamped_low, next_report.clamped);
          check_field("avg_lux_q4", avg_lux_q4, next_report.avg_lux);
          check_field("light_class", light_class, next_report.light_class);
          check_field("red_level", red_level, next_report.red);
          check_field("green_level", green_level, next_report.green);
          check_field("blue_level", blue_level, next_report.blue);
          check_field("buzzer_on", buzzer_on, next_report.buzzer);
          if (next_report.light_class <= CLASS_BRIGHT) class_tally[next_report.light_class]++;
          if (next_report.clamped) low_clamps++;
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_reports.size());
      $display("FAIL light_level_classifier_core");
      $finish;
    end
  end

  task automatic wait_until_drained();
    while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    // a trailing partial group may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_CAL_OFFSET:  cal_offset = value[LUX_W-1:0];
      CFG_CAL_GAIN:    cal_gain = value[GAIN_W-1:0];
      CFG_LUX_MAX:     lux_max = value[LUX_W-1:0];
      CFG_DARK_LIMIT:  dark_limit = value[LUX_W-1:0];
      CFG_NORMAL_MAX:  normal_limit = value[LUX_W-1:0];
      CFG_BRIGHT_FULL: bright_full = value[BFL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(input int unsigned offset, input int unsigned gain,
                                 input int unsigned top, input int unsigned dark,
                                 input int unsigned normal, input int unsigned full);
    write_reg(CFG_CAL_OFFSET, offset);
    write_reg(CFG_CAL_GAIN, gain);
    write_reg(CFG_LUX_MAX, top);
    write_reg(CFG_DARK_LIMIT, dark);
    write_reg(CFG_NORMAL_MAX, normal);
    write_reg(CFG_BRIGHT_FULL, full);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly steady light levels per group, some flat groups and plain noise
  task automatic queue_random_samples(input int count);
    int style;
    int base;
    int val;
    style = 0;
    base = 0;
    for (int n = 0; n < count; n++) begin
      if (n % OVERSAMPLE == 0) begin
        style = $urandom_range(9);
        case ($urandom_range(3))
          0: base = 0;
          1: base = ADC_MAX;
          default: base = $urandom_range(ADC_MAX);
        endcase
      end
      if (style < 6) begin
        val = base + int'($urandom_range(30)) - 15;
        if (val < 0) val = 0;
        if (val > ADC_MAX) val = ADC_MAX;
      end else if (style == 6) begin
        val = base;
      end else begin
        val = $urandom_range(ADC_MAX);
      end
      pending_samples.push_back(val[ADC_W-1:0]);
    end
  endtask

  initial begin
    int unsigned top;
    int unsigned dark;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: clamp low, brightest, mid scale, alternating extremes, then a partial
    // group of single bits left open
    pending_samples = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                        10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
                        10'd512, 10'd512, 10'd512, 10'd512, 10'd512,
                        10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0,
                        10'd1, 10'd2, 10'd4};
    for (int phase = 1; phase <= PHASES; phase++) begin
      wait_until_drained();
      case (phase)
        1: program_setting(131071, 0, 131071, 0, 0, 8191);
        2: program_setting(0, 262143, 0, 131071, 131071, 0);
        3: program_setting(60000, 40000, 50000, 1000, 20000, 100);
        4: program_setting(40000, 20000, 131071, 2000, 1600, 300);
        5: program_setting(CAL_OFFSET_RST, CAL_GAIN_RST, LUX_MAX_RST, DARK_LIMIT_RST,
                           NORMAL_MAX_RST, BRIGHT_FULL_RST);
        default: begin
          top = $urandom_range(131071, 20000);
          dark = $urandom_range(top / 4);
          program_setting($urandom_range(131071), $urandom_range(262143), top, dark,
                          $urandom_range(top / 2, dark), $urandom_range(8191));
        end
      endcase
      @(negedge clk);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      queue_random_samples(ITEMS_PER_PHASE);
    end
    wait_until_drained();
    $display("%0d samples in, %0d results checked across %0d register settings",
             samples_sent, results_seen, settings_used);
    $display("dark %0d, normal %0d, bright %0d, low clamps %0d, mismatches %0d",
             class_tally[0], class_tally[1], class_tally[2], low_clamps, fail_count);
    if (fail_count == 0)
      $display("PASS light_level_classifier_core");
    else
      $display("FAIL light_level_classifier_core");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/llc_pkg.sv
hw/rtl/llc_calib.sv
hw/rtl/llc_window_ram.sv
hw/rtl/llc_div.sv
hw/rtl/light_level_classifier_core.sv
hw/rtl/llc_checker.sv
test/testbench.sv
